[src/sfa_pkg.sv]
// Shared types, command codes and constants for the sprite frame animator.
// No dependencies; used by every module under src except sfa_ram.
package sfa_pkg;

  localparam int DIRECTIONS_DEF = 8;
  localparam int FRAMES_DEF     = 8;

  localparam int NOW_W  = 32;
  localparam int TILE_W = 16;
  localparam int DUR_W  = 16;
  localparam int SEL_W  = 3;
  localparam int FC_W   = 4;
  localparam int TL_W   = 34;
  localparam int DIV_STEPS = NOW_W;

  localparam logic [DUR_W-1:0]  DUR_RESET  = 16'd50;
  localparam logic [TILE_W-1:0] TILE_RESET = 16'd0;

  localparam logic [2:0] CMD_WRITE     = 3'd0;
  localparam logic [2:0] CMD_SET_DIR   = 3'd1;
  localparam logic [2:0] CMD_SET_FRAME = 3'd2;
  localparam logic [2:0] CMD_ENABLE    = 3'd3;
  localparam logic [2:0] CMD_PAUSE     = 3'd4;
  localparam logic [2:0] CMD_DISABLE   = 3'd5;
  localparam logic [2:0] CMD_TICK      = 3'd6;
  localparam logic [2:0] CMD_SPARE     = 3'd7;

  typedef struct packed {
    logic [2:0]        command;
    logic [NOW_W-1:0]  now;
    logic [SEL_W-1:0]  dir_sel;
    logic [SEL_W-1:0]  frame_sel;
    logic [TILE_W-1:0] tile_id;
    logic [DUR_W-1:0]  duration;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_out;
    logic [SEL_W-1:0]  frame_out;
    logic [SEL_W-1:0]  dir_out;
    logic              animating;
    logic              rejected;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LATCH,
    OP_EXEC,
    OP_RD_CUR,
    OP_LOAD_TL,
    OP_STEP,
    OP_ADD_DUR,
    OP_SUM_CLR,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_OUT_LOAD
  } ctrl_op_t;

  typedef struct packed {
    ctrl_op_t op;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       anim_on;
    logic       tl_neg;
    logic       sum_last;
    logic       div_last;
  } status_t;

endpackage

[src/sprite_frame_animator_top.sv]
// Sprite frame animator: one result transaction per input transaction.
// Each input is latched and executed; enable also loads the current frame's duration as
// time left, and a tick that runs past it steps the frame and adds the new duration; if
// still behind, the cycle sum is accumulated, the overshoot reduced modulo it bit-serially
// and frames stepped until time left is no longer negative.
// One item in flight; the output register frees the input. Reset (rst, sync): tables 50/0.
module sprite_frame_animator_top #(
  parameter int DIRECTIONS = sfa_pkg::DIRECTIONS_DEF,
  parameter int FRAMES     = sfa_pkg::FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfa_pkg::out_item_t out_data
);

  // Command/status pair between the sequencer and the datapath.
  sfa_pkg::ctrl_t   ctrl;
  sfa_pkg::status_t status;

  // Controller: steps through execute, frame advance, cycle sum, remainder
  // and result stages; holds the output valid flag.
  sfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Datapath: item latch, animation registers, tile and duration RAMs with
  // per-entry written bits, cycle accumulator and bit-serial remainder unit.
  sfa_datapath #(
    .DIRECTIONS (DIRECTIONS),
    .FRAMES     (FRAMES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_data),
    .ctrl     (ctrl),
    .status   (status),
    .out_item (out_data)
  );

endmodule

[src/sfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sfa_datapath.sv]
// Datapath: animation state, tile/duration tables, cycle sum and remainder unit.
// Depends on sfa_pkg and sfa_ram; driven by sfa_ctrl through ctrl_t.
module sfa_datapath #(
  parameter int DIRECTIONS = sfa_pkg::DIRECTIONS_DEF,
  parameter int FRAMES     = sfa_pkg::FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sfa_pkg::in_item_t  in_item,
  input  sfa_pkg::ctrl_t     ctrl,
  output sfa_pkg::status_t   status,
  output sfa_pkg::out_item_t out_item
);

  localparam int DEPTH = DIRECTIONS * FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
  localparam int SUM_W = sfa_pkg::DUR_W + $clog2(FRAMES);
  localparam int CW    = $clog2(sfa_pkg::DIV_STEPS);

  function automatic logic [AW-1:0] addr_of(input logic [3:0] d, input logic [3:0] f);
    addr_of = AW'(int'(d) * FRAMES + int'(f));
  endfunction

  sfa_pkg::in_item_t item;
  logic [sfa_pkg::SEL_W-1:0]  cur_dir;
  logic [sfa_pkg::SEL_W-1:0]  cur_frame;
  logic [sfa_pkg::NOW_W-1:0]  tref;
  logic signed [sfa_pkg::TL_W-1:0] tl;
  logic                       anim_on;
  logic                       rejected;
  logic [sfa_pkg::FC_W-1:0]   fcount [DIRECTIONS];
  logic [DEPTH-1:0]           valid;
  logic                       vq;
  logic [SUM_W-1:0]           sum;
  logic [3:0]                 idx;
  logic [sfa_pkg::NOW_W-1:0]  dvx;
  logic [SUM_W-1:0]           rem;
  logic [CW-1:0]              dcnt;
  sfa_pkg::out_item_t         out_reg;

  logic [sfa_pkg::FC_W-1:0]   fc_cur;
  logic [4:0]                 len;
  logic [3:0]                 nf_inc;
  logic [sfa_pkg::SEL_W-1:0]  nf;
  logic                       wr_ok;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [sfa_pkg::DUR_W-1:0]  d_rdata;
  logic [sfa_pkg::TILE_W-1:0] t_rdata;
  logic [sfa_pkg::DUR_W-1:0]  dur_q;
  logic [sfa_pkg::TILE_W-1:0] tile_q;
  logic [sfa_pkg::NOW_W-1:0]  elapsed;
  logic [SUM_W:0]             shifted;

  assign fc_cur = fcount[DW'(cur_dir)];

  // cycle length: a zero frame count still cycles over frame 0
  always_comb begin
    if (fc_cur == '0) begin
      len = 5'd1;
    end else if ({1'b0, fc_cur} > 5'(FRAMES)) begin
      len = 5'(FRAMES);
    end else begin
      len = {1'b0, fc_cur};
    end
  end

  assign nf_inc = {1'b0, cur_frame} + 4'd1;
  assign nf = (nf_inc >= fc_cur || {1'b0, nf_inc} >= 5'(FRAMES)) ?
              '0 : nf_inc[sfa_pkg::SEL_W-1:0];

  assign wr_ok = (item.duration != '0) && (int'(item.dir_sel) < DIRECTIONS) &&
                 (int'(item.frame_sel) < FRAMES);
  assign we    = (ctrl.op == sfa_pkg::OP_EXEC) && (item.command == sfa_pkg::CMD_WRITE) &&
                 wr_ok;
  assign waddr = addr_of({1'b0, item.dir_sel}, {1'b0, item.frame_sel});
  assign re    = (ctrl.op == sfa_pkg::OP_RD_CUR) || (ctrl.op == sfa_pkg::OP_SUM_RD);
  assign raddr = (ctrl.op == sfa_pkg::OP_SUM_RD) ? addr_of({1'b0, cur_dir}, idx) :
                                                   addr_of({1'b0, cur_dir}, {1'b0, cur_frame});

  sfa_ram #(.WIDTH(sfa_pkg::DUR_W), .DEPTH(DEPTH)) u_dur_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.duration),
    .re    (re),
    .raddr (raddr),
    .rdata (d_rdata)
  );

  sfa_ram #(.WIDTH(sfa_pkg::TILE_W), .DEPTH(DEPTH)) u_tile_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.tile_id),
    .re    (re),
    .raddr (raddr),
    .rdata (t_rdata)
  );

  // never-written entries read as their reset values
  assign dur_q   = vq ? d_rdata : sfa_pkg::DUR_RESET;
  assign tile_q  = vq ? t_rdata : sfa_pkg::TILE_RESET;
  assign elapsed = item.now - tref;
  assign shifted = {rem, dvx[sfa_pkg::NOW_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
    if (re) begin
      vq <= valid[raddr];
    end
  end

  for (genvar d = 0; d < DIRECTIONS; d++) begin : g_fc
    always_ff @(posedge clk) begin
      if (rst) begin
        fcount[d] <= '0;
      end else if (we && int'(item.dir_sel) == d &&
                   ({1'b0, item.frame_sel} + 4'd1) > fcount[d]) begin
        fcount[d] <= {1'b0, item.frame_sel} + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_dir   <= '0;
      cur_frame <= '0;
      tref      <= '0;
      tl        <= '0;
      anim_on   <= 1'b0;
    end else begin
      unique case (ctrl.op)
        sfa_pkg::OP_EXEC: begin
          unique case (item.command)
            sfa_pkg::CMD_SET_DIR: begin
              if (int'(item.dir_sel) < DIRECTIONS) begin
                cur_dir <= item.dir_sel;
                if (item.restart) begin
                  tref <= item.now;
                end
              end
            end
            sfa_pkg::CMD_SET_FRAME: begin
              if (int'(item.frame_sel) < FRAMES) begin
                cur_frame <= item.frame_sel;
                tref      <= item.now;
              end
            end
            sfa_pkg::CMD_ENABLE: begin
              if (!anim_on) begin
                anim_on <= 1'b1;
                tref    <= item.now;
              end
            end
            sfa_pkg::CMD_PAUSE: begin
              anim_on <= 1'b0;
            end
            sfa_pkg::CMD_DISABLE: begin
              cur_frame <= '0;
              tref      <= item.now;
              anim_on   <= 1'b0;
            end
            sfa_pkg::CMD_TICK: begin
              if (anim_on) begin
                tref <= item.now;
                tl   <= tl - signed'({2'b00, elapsed});
              end
            end
            default: begin
            end
          endcase
        end
        sfa_pkg::OP_LOAD_TL: tl <= signed'({18'd0, dur_q});
        sfa_pkg::OP_STEP:    cur_frame <= nf;
        sfa_pkg::OP_ADD_DUR: tl <= tl + signed'({18'd0, dur_q});
        // -(rem + 1) is the bitwise complement of rem
        sfa_pkg::OP_DIV_END: tl <= ~signed'({{(sfa_pkg::TL_W - SUM_W){1'b0}}, rem});
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      sfa_pkg::OP_LATCH: begin
        item     <= in_item;
        rejected <= 1'b0;
      end
      sfa_pkg::OP_EXEC: begin
        rejected <= (item.command == sfa_pkg::CMD_WRITE) && !wr_ok;
      end
      sfa_pkg::OP_SUM_CLR: begin
        sum <= '0;
        idx <= '0;
      end
      sfa_pkg::OP_SUM_ACC: begin
        sum <= sum + SUM_W'(dur_q);
        idx <= idx + 4'd1;
      end
      // x = -tl - 1, reduced modulo the cycle sum
      sfa_pkg::OP_DIV_INIT: begin
        dvx  <= ~tl[sfa_pkg::NOW_W-1:0];
        rem  <= '0;
        dcnt <= '0;
      end
      sfa_pkg::OP_DIV_STEP: begin
        if (shifted >= {1'b0, sum}) begin
          rem <= SUM_W'(shifted - {1'b0, sum});
        end else begin
          rem <= shifted[SUM_W-1:0];
        end
        dvx  <= dvx << 1;
        dcnt <= dcnt + CW'(1);
      end
      sfa_pkg::OP_OUT_LOAD: begin
        out_reg.tile_out  <= tile_q;
        out_reg.frame_out <= cur_frame;
        out_reg.dir_out   <= cur_dir;
        out_reg.animating <= anim_on;
        out_reg.rejected  <= rejected;
      end
      default: begin
      end
    endcase
  end

  assign status.cmd      = item.command;
  assign status.anim_on  = anim_on;
  assign status.tl_neg   = tl[sfa_pkg::TL_W-1];
  assign status.sum_last = ({1'b0, idx} == len - 5'd1);
  assign status.div_last = (dcnt == CW'(sfa_pkg::DIV_STEPS - 1));
  assign out_item        = out_reg;

endmodule

[src/sfa_ctrl.sv]
// Controller: sequences each transaction through the datapath and owns
// both handshakes. Depends on sfa_pkg.
module sfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sfa_pkg::status_t status,
  output sfa_pkg::ctrl_t   ctrl
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_EN_RD, S_EN_LD, S_T_CHK, S_F_RD, S_F_ADD, S_F_CHK,
    S_SUM_RD, S_SUM_ACC, S_DIV_INIT, S_DIV, S_DIV_END,
    S_L_CHK, S_L_RD, S_L_ADD, S_OUT_RD, S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctrl.op    = sfa_pkg::OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = sfa_pkg::OP_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.op = sfa_pkg::OP_EXEC;
        if (status.cmd == sfa_pkg::CMD_ENABLE && !status.anim_on) begin
          state_next = S_EN_RD;
        end else if (status.cmd == sfa_pkg::CMD_TICK && status.anim_on) begin
          state_next = S_T_CHK;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_EN_RD: begin
        ctrl.op    = sfa_pkg::OP_RD_CUR;
        state_next = S_EN_LD;
      end
      S_EN_LD: begin
        ctrl.op    = sfa_pkg::OP_LOAD_TL;
        state_next = S_OUT_RD;
      end
      S_T_CHK: begin
        if (status.tl_neg) begin
          ctrl.op    = sfa_pkg::OP_STEP;
          state_next = S_F_RD;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_F_RD: begin
        ctrl.op    = sfa_pkg::OP_RD_CUR;
        state_next = S_F_ADD;
      end
      S_F_ADD: begin
        ctrl.op    = sfa_pkg::OP_ADD_DUR;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (status.tl_neg) begin
          ctrl.op    = sfa_pkg::OP_SUM_CLR;
          state_next = S_SUM_RD;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_SUM_RD: begin
        ctrl.op    = sfa_pkg::OP_SUM_RD;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        ctrl.op    = sfa_pkg::OP_SUM_ACC;
        state_next = status.sum_last ? S_DIV_INIT : S_SUM_RD;
      end
      S_DIV_INIT: begin
        ctrl.op    = sfa_pkg::OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctrl.op = sfa_pkg::OP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: begin
        ctrl.op    = sfa_pkg::OP_DIV_END;
        state_next = S_L_CHK;
      end
      S_L_CHK: begin
        if (status.tl_neg) begin
          ctrl.op    = sfa_pkg::OP_STEP;
          state_next = S_L_RD;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_L_RD: begin
        ctrl.op    = sfa_pkg::OP_RD_CUR;
        state_next = S_L_ADD;
      end
      S_L_ADD: begin
        ctrl.op    = sfa_pkg::OP_ADD_DUR;
        state_next = S_L_CHK;
      end
      S_OUT_RD: begin
        ctrl.op    = sfa_pkg::OP_RD_CUR;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          ctrl.op    = sfa_pkg::OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[tb/sfa_checker.sv]
// Scoreboard for the sprite frame animator: watches both channels, keeps its own
// copy of the animation tables and state, and compares each result transaction.
// Depends on sfa_pkg for the payload types and command codes.
module sfa_checker
  import sfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRS = DIRECTIONS_DEF;
  localparam int FRMS = FRAMES_DEF;

  logic [DUR_W-1:0]  dur_tab  [DIRS][FRMS];
  logic [TILE_W-1:0] tile_tab [DIRS][FRMS];
  logic [FC_W-1:0]   fcnt     [DIRS];
  logic [SEL_W-1:0]  cur_dir;
  logic [SEL_W-1:0]  cur_frame;
  logic [NOW_W-1:0]  t_ref;
  longint            t_left;
  logic              anim;

  out_item_t tile_forecast[$];

  assign outstanding = tile_forecast.size();

  function automatic void clear_state();
    for (int d = 0; d < DIRS; d++) begin
      for (int f = 0; f < FRMS; f++) begin
        dur_tab[d][f]  = DUR_RESET;
        tile_tab[d][f] = TILE_RESET;
      end
      fcnt[d] = '0;
    end
    cur_dir   = '0;
    cur_frame = '0;
    t_ref     = '0;
    t_left    = 0;
    anim      = 1'b0;
  endfunction

  // wraps at the direction's frame count; an empty direction pins frame 0
  function automatic logic [SEL_W-1:0] following_frame(logic [SEL_W-1:0] f);
    int n;
    n = int'(f) + 1;
    if (n >= int'(fcnt[cur_dir]) || n >= FRMS) n = 0;
    return n[SEL_W-1:0];
  endfunction

  function automatic void step_frame();
    longint d;
    cur_frame = following_frame(cur_frame);
    d = longint'(dur_tab[cur_dir][cur_frame]);
    t_left = t_left + d;
  endfunction

  function automatic void advance_clock(logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] span;
    longint elapsed;
    longint cycle_ms;
    longint d;
    int     len;
    if (!anim) return;
    // elapsed time wraps at the timestamp width
    span    = now - t_ref;
    elapsed = longint'(span);
    t_ref   = now;
    t_left  = t_left - elapsed;
    if (t_left >= 0) return;
    step_frame();
    if (t_left < 0) begin
      // now inside the cycle: drop whole loops of the animation at once
      len = int'(fcnt[cur_dir]);
      if (len == 0) len = 1;
      if (len > FRMS) len = FRMS;
      cycle_ms = 0;
      for (int i = 0; i < len; i++) begin
        d = longint'(dur_tab[cur_dir][i]);
        cycle_ms = cycle_ms + d;
      end
      if (cycle_ms > 0) t_left = t_left + ((-t_left - 1) / cycle_ms) * cycle_ms;
    end
    while (t_left < 0) step_frame();
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    logic      refused;
    refused = 1'b0;
    case (it.command)
      CMD_WRITE: begin
        if (it.duration == '0) begin
          refused = 1'b1;
        end else begin
          tile_tab[it.dir_sel][it.frame_sel] = it.tile_id;
          dur_tab[it.dir_sel][it.frame_sel]  = it.duration;
          if (int'(it.frame_sel) + 1 > int'(fcnt[it.dir_sel]))
            fcnt[it.dir_sel] = FC_W'(int'(it.frame_sel) + 1);
        end
      end
      CMD_SET_DIR: begin
        cur_dir = it.dir_sel;
        if (it.restart) t_ref = it.now;
      end
      CMD_SET_FRAME: begin
        cur_frame = it.frame_sel;
        t_ref     = it.now;
      end
      CMD_ENABLE: begin
        if (!anim) begin
          anim   = 1'b1;
          t_ref  = it.now;
          t_left = longint'(dur_tab[cur_dir][cur_frame]);
        end
      end
      CMD_PAUSE: anim = 1'b0;
      CMD_DISABLE: begin
        cur_frame = '0;
        t_ref     = it.now;
        anim      = 1'b0;
      end
      CMD_TICK: advance_clock(it.now);
      default: ;
    endcase
    r.tile_out  = tile_tab[cur_dir][cur_frame];
    r.frame_out = cur_frame;
    r.dir_out   = cur_dir;
    r.animating = anim;
    r.rejected  = refused;
    return r;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_state();
      tile_forecast.delete();
      mismatches = 0;
    end else begin
      // results first: nothing accepted on this edge can already have come out
      if (out_valid && out_ready) begin
        if (tile_forecast.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction %h", $time, out_data);
        end else begin
          want = tile_forecast.pop_front();
          check_field("tile_out",  want.tile_out,  out_data.tile_out);
          check_field("frame_out", want.frame_out, out_data.frame_out);
          check_field("dir_out",   want.dir_out,   out_data.dir_out);
          check_field("animating", want.animating, out_data.animating);
          check_field("rejected",  want.rejected,  out_data.rejected);
        end
      end
      if (in_valid && in_ready) tile_forecast.push_back(apply_command(in_data));
    end
  end

endmodule

[tb/sprite_frame_animator_top_test.sv]
// Top-level testbench for sprite_frame_animator_top: clock, reset, command stimulus
// and result-side backpressure. Depends on sfa_pkg and on sfa_checker for scoring.
module sprite_frame_animator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfa_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int        mismatches;
  int        outstanding;

  // idling is switched on in windows; off for the tail of the run
  bit        idle_on = 1'b0;
  int        stall_left = 0;
  logic [NOW_W-1:0] clock_ms = '0;

  sprite_frame_animator_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sfa_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: reports failure and stops the run if it has not finished in time; the limit
  // allows for a long tick plus a full sender gap and receiver stall on each transaction.
  initial begin
    #10_000_000;
    $display("sprite_frame_animator_top verification failed");
    $finish;
  end

  // Result-side backpressure: out_ready drops in random bursts.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t cmd_item(logic [2:0] cmd, logic [NOW_W-1:0] now,
                                        logic [SEL_W-1:0] dsel, logic [SEL_W-1:0] fsel,
                                        logic [TILE_W-1:0] tile, logic [DUR_W-1:0] dur,
                                        logic rs);
    in_item_t it;
    it.command   = cmd;
    it.now       = now;
    it.dir_sel   = dsel;
    it.frame_sel = fsel;
    it.tile_id   = tile;
    it.duration  = dur;
    it.restart   = rs;
    return it;
  endfunction

  // Random command with a running millisecond clock. Ticks dominate so the
  // animation really runs; short durations make ticks cross several frames.
  function automatic in_item_t next_random_command();
    in_item_t    it;
    logic [95:0] noise;
    int          pick;
    int          jump;
    noise = {$urandom, $urandom, $urandom};
    it    = noise[$bits(in_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    jump  = $urandom_range(0, 9);
    if (pick < 22) begin
      it.command   = CMD_WRITE;
      it.frame_sel = SEL_W'($urandom_range(0, $urandom_range(0, 7)));
      case ($urandom_range(0, 9))
        0:       it.duration = '0;
        1:       it.duration = DUR_W'($urandom);
        default: it.duration = DUR_W'($urandom_range(1, 40));
      endcase
    end else if (pick < 30) begin
      it.command = CMD_SET_DIR;
    end else if (pick < 36) begin
      it.command = CMD_SET_FRAME;
    end else if (pick < 46) begin
      it.command = CMD_ENABLE;
    end else if (pick < 51) begin
      it.command = CMD_PAUSE;
    end else if (pick < 55) begin
      it.command = CMD_DISABLE;
    end else if (pick < 58) begin
      it.command = CMD_SPARE;  // unused code, must be a no-op
    end else begin
      it.command = CMD_TICK;
    end
    if (it.command == CMD_TICK) begin
      if (jump < 7)      clock_ms = clock_ms + $urandom_range(0, 60);
      else if (jump < 9) clock_ms = clock_ms + $urandom_range(0, 1000);
      else               clock_ms = $urandom;  // long gap, may wrap backwards
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 20);
    end
    it.now = clock_ms;
    return it;
  endfunction

  // Holds valid until the transaction is taken; valid is never dropped here.
  task automatic offer(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    in_item_t directed[$];

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every command, refusal, frame count zero,
    // frame beyond the count, re-enable, long and wrapping elapsed times.
    directed.push_back(cmd_item(CMD_TICK,      32'd100,       3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_WRITE,     32'd0,         3'd0, 3'd0, 16'hFFFF, 16'd0,     1'b1));
    directed.push_back(cmd_item(CMD_WRITE,     32'd0,         3'd0, 3'd0, 16'h1234, 16'd3,     1'b0));
    directed.push_back(cmd_item(CMD_WRITE,     32'd0,         3'd0, 3'd2, 16'hABCD, 16'hFFFF,  1'b0));
    directed.push_back(cmd_item(CMD_WRITE,     32'hFFFFFFFF,  3'd7, 3'd7, 16'hFFFF, 16'd1,     1'b1));
    directed.push_back(cmd_item(CMD_WRITE,     32'd0,         3'd7, 3'd0, 16'h0001, 16'd2,     1'b0));
    directed.push_back(cmd_item(CMD_ENABLE,    32'd1000,      3'd7, 3'd7, 16'hFFFF, 16'hFFFF,  1'b1));
    directed.push_back(cmd_item(CMD_ENABLE,    32'd5000,      3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'd1002,      3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'd1010,      3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'hFFFFFFF0,  3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'h00000010,  3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_SET_FRAME, 32'd20,        3'd0, 3'd7, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'd200,       3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_SET_DIR,   32'd9999,      3'd7, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'd300,       3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_SET_DIR,   32'd400,       3'd3, 3'd0, 16'h0000, 16'd0,     1'b1));
    directed.push_back(cmd_item(CMD_TICK,      32'd100000,    3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_PAUSE,     32'd0,         3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'd200000,    3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_SPARE,     32'hA5A5A5A5,  3'd5, 3'd2, 16'h5A5A, 16'd0,     1'b1));
    directed.push_back(cmd_item(CMD_ENABLE,    32'hFFFFFFFF,  3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_TICK,      32'h00000100,  3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_DISABLE,   32'd5,         3'd0, 3'd0, 16'h0000, 16'd0,     1'b0));
    directed.push_back(cmd_item(CMD_SET_DIR,   32'd0,         3'd0, 3'd0, 16'h0000, 16'd0,     1'b1));

    foreach (directed[k]) offer(directed[k]);

    // Random part: idling alternates on and off every 100 transactions and
    // stays off for the last stretch so the tail runs back to back.
    for (int i = 0; i < 900; i++) begin
      idle_on = (i < 800) && ((i / 100) % 2 == 0);
      offer(next_random_command());
      maybe_gap();
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    // Drain: wait for every forecast result, then allow for the longest tick.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (mismatches == 0) begin
      $display("sprite_frame_animator_top verification clean");
    end else begin
      $display("sprite_frame_animator_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/sfa_pkg.sv
src/sfa_ram.sv
src/sfa_datapath.sv
src/sfa_ctrl.sv
src/sprite_frame_animator_top.sv
tb/sfa_checker.sv
tb/sprite_frame_animator_top_test.sv
